FILE: rtl/dfp_pkg.sv
package dfp_pkg;

  localparam int unsigned MAX_FRACTION_DIGITS = 9;

  typedef struct packed {
    logic [7:0] character;
    logic       end_of_text;
  } in_t;

  typedef struct packed {
    logic        valid_res;
    logic [63:0] frequency_hz;
  } out_t;

  typedef enum logic [2:0] {
    PH_FIRST,
    PH_WHOLE,
    PH_FRAC,
    PH_SPACE,
    PH_HZ,
    PH_KHZ,
    PH_MHZ,
    PH_GHZ
  } phase_t;

  typedef enum logic [1:0] {
    ST_CHAR,
    ST_SCALE,
    ST_SUM
  } state_t;

  typedef struct packed {
    logic take_char;
    logic start;
    logic step;
    logic finish;
  } cmd_t;

  typedef struct packed {
    logic scale_done;
    logic out_free;
  } status_t;

  // 2^35 / 10 rounded up; exact divide by ten for 32-bit operands
  localparam logic [31:0] DIV10_RECIP = 32'hCCCC_CCCD;
  localparam int unsigned DIV10_SHIFT = 35;

endpackage

FILE: rtl/dfp_ctrl.sv
module dfp_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  input  logic             in_end,
  output logic             in_ready,
  input  dfp_pkg::status_t status,
  output dfp_pkg::cmd_t    cmd
);

  dfp_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= dfp_pkg::ST_CHAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    case (state_r)
      dfp_pkg::ST_CHAR: begin
        in_ready = 1'b1;
        if (in_valid) begin
          if (in_end) begin
            cmd.start = 1'b1;
            state_nxt = dfp_pkg::ST_SCALE;
          end else begin
            cmd.take_char = 1'b1;
          end
        end
      end
      dfp_pkg::ST_SCALE: begin
        cmd.step = 1'b1;
        if (status.scale_done) state_nxt = dfp_pkg::ST_SUM;
      end
      dfp_pkg::ST_SUM: begin
        if (status.out_free) begin
          cmd.finish = 1'b1;
          state_nxt  = dfp_pkg::ST_CHAR;
        end
      end
      default: state_nxt = dfp_pkg::ST_CHAR;
    endcase
  end

endmodule

FILE: rtl/dfp_datapath.sv
module dfp_datapath (
  input  logic             clk,
  input  logic             rst_n,
  input  dfp_pkg::cmd_t    cmd,
  input  logic [7:0]       character,
  output dfp_pkg::status_t status,
  output logic             out_valid,
  input  logic             out_ready,
  output dfp_pkg::out_t    out_data
);

  // token parse state
  dfp_pkg::phase_t phase_r, phase_nxt;
  logic [63:0] whole_r, whole_nxt;
  logic        whole_ovf_r, whole_ovf_nxt;
  logic [29:0] frac_r, frac_nxt;
  logic [3:0]  frac_cnt_r, frac_cnt_nxt;
  logic [1:0]  sfx_r, sfx_nxt;
  logic        err_r, err_nxt;

  // scaling state
  logic [63:0] hi_r;
  logic        hi_ovf_r;
  logic [3:0]  hi_cnt_r;
  logic [63:0] lo_r;
  logic [3:0]  lo_cnt_r;
  logic        lo_mul_r;
  logic        ok_r;

  logic        out_valid_r;
  dfp_pkg::out_t out_data_r;

  logic        is_digit, is_space;
  logic [3:0]  digit;
  logic [67:0] whole_x10;
  logic        sfx_start_ok;
  dfp_pkg::phase_t sfx_phase;
  logic [3:0]  unit_exp;
  logic        end_ok;
  logic [67:0] hi_x10;
  logic [63:0] lo_x10;
  logic [63:0] lo_prod;
  logic [64:0] sum;
  logic        res_ok;

  assign is_digit = character inside {[8'h30:8'h39]};
  assign is_space = (character == 8'h20) || (character inside {[8'h09:8'h0D]});
  assign digit    = 4'(character - 8'h30);
  assign whole_x10 = {1'b0, whole_r, 3'b000} + {3'b000, whole_r, 1'b0} + {64'd0, digit};

  always_comb begin
    sfx_start_ok = 1'b1;
    sfx_phase    = dfp_pkg::PH_HZ;
    case (character)
      8'h48:   sfx_phase = dfp_pkg::PH_HZ;   // H
      8'h4B:   sfx_phase = dfp_pkg::PH_KHZ;  // K
      8'h4D:   sfx_phase = dfp_pkg::PH_MHZ;  // M
      8'h47:   sfx_phase = dfp_pkg::PH_GHZ;  // G
      default: sfx_start_ok = 1'b0;
    endcase
  end

  always_comb begin
    phase_nxt     = phase_r;
    whole_nxt     = whole_r;
    whole_ovf_nxt = whole_ovf_r;
    frac_nxt      = frac_r;
    frac_cnt_nxt  = frac_cnt_r;
    sfx_nxt       = sfx_r;
    err_nxt       = err_r;
    if (cmd.start) begin
      phase_nxt     = dfp_pkg::PH_FIRST;
      whole_nxt     = '0;
      whole_ovf_nxt = 1'b0;
      frac_nxt      = '0;
      frac_cnt_nxt  = '0;
      sfx_nxt       = '0;
      err_nxt       = 1'b0;
    end else if (cmd.take_char && !err_r) begin
      case (phase_r)
        dfp_pkg::PH_FIRST: begin
          if (is_digit) begin
            whole_nxt = {60'd0, digit};
            phase_nxt = dfp_pkg::PH_WHOLE;
          end else begin
            err_nxt = 1'b1;
          end
        end
        dfp_pkg::PH_WHOLE: begin
          if (is_digit) begin
            if (whole_x10[67:64] != 4'd0) whole_ovf_nxt = 1'b1;
            else whole_nxt = whole_x10[63:0];
          end else if (character == 8'h2E) begin
            phase_nxt = dfp_pkg::PH_FRAC;
          end else if (is_space) begin
            phase_nxt = dfp_pkg::PH_SPACE;
          end else if (sfx_start_ok) begin
            phase_nxt = sfx_phase;
            sfx_nxt   = 2'd1;
          end else begin
            err_nxt = 1'b1;
          end
        end
        dfp_pkg::PH_FRAC: begin
          if (is_digit) begin
            if (frac_cnt_r < 4'(dfp_pkg::MAX_FRACTION_DIGITS)) begin
              frac_nxt = {frac_r[26:0], 3'b000} + {frac_r[28:0], 1'b0} + {26'd0, digit};
              frac_cnt_nxt = frac_cnt_r + 4'd1;
            end
          end else if (is_space) begin
            phase_nxt = dfp_pkg::PH_SPACE;
          end else if (sfx_start_ok) begin
            phase_nxt = sfx_phase;
            sfx_nxt   = 2'd1;
          end else begin
            err_nxt = 1'b1;
          end
        end
        dfp_pkg::PH_SPACE: begin
          if (!is_space) begin
            if (sfx_start_ok) begin
              phase_nxt = sfx_phase;
              sfx_nxt   = 2'd1;
            end else begin
              err_nxt = 1'b1;
            end
          end
        end
        dfp_pkg::PH_HZ: begin
          if (sfx_r == 2'd1 && character == 8'h5A) sfx_nxt = 2'd2;
          else err_nxt = 1'b1;
        end
        default: begin
          // KHZ, MHZ, GHZ: H then Z after the lead letter
          if (sfx_r == 2'd1 && character == 8'h48) sfx_nxt = 2'd2;
          else if (sfx_r == 2'd2 && character == 8'h5A) sfx_nxt = 2'd3;
          else err_nxt = 1'b1;
        end
      endcase
    end
  end

  // unit exponent and suffix completeness at the end beat
  always_comb begin
    unit_exp = 4'd6;
    end_ok   = 1'b1;
    case (phase_r)
      dfp_pkg::PH_FIRST: end_ok = 1'b0;
      dfp_pkg::PH_HZ: begin
        unit_exp = 4'd0;
        end_ok   = (sfx_r == 2'd2);
      end
      dfp_pkg::PH_KHZ: begin
        unit_exp = 4'd3;
        end_ok   = (sfx_r == 2'd3);
      end
      dfp_pkg::PH_MHZ: end_ok = (sfx_r == 2'd3);
      dfp_pkg::PH_GHZ: begin
        unit_exp = 4'd9;
        end_ok   = (sfx_r == 2'd3);
      end
      default: ;
    endcase
  end

  assign hi_x10  = {1'b0, hi_r, 3'b000} + {3'b000, hi_r, 1'b0};
  assign lo_x10  = {lo_r[60:0], 3'b000} + {lo_r[62:0], 1'b0};
  assign lo_prod = lo_r[31:0] * dfp_pkg::DIV10_RECIP;
  assign sum     = {1'b0, hi_r} + {1'b0, lo_r};
  assign res_ok  = ok_r && !hi_ovf_r && !sum[64];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= dfp_pkg::PH_FIRST;
      whole_r     <= '0;
      whole_ovf_r <= 1'b0;
      frac_r      <= '0;
      frac_cnt_r  <= '0;
      sfx_r       <= '0;
      err_r       <= 1'b0;
      hi_cnt_r    <= '0;
      lo_cnt_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      phase_r     <= phase_nxt;
      whole_r     <= whole_nxt;
      whole_ovf_r <= whole_ovf_nxt;
      frac_r      <= frac_nxt;
      frac_cnt_r  <= frac_cnt_nxt;
      sfx_r       <= sfx_nxt;
      err_r       <= err_nxt;

      if (cmd.start) begin
        hi_cnt_r <= unit_exp;
        if (unit_exp >= frac_cnt_r) begin
          lo_mul_r <= 1'b1;
          lo_cnt_r <= unit_exp - frac_cnt_r;
        end else begin
          lo_mul_r <= 1'b0;
          lo_cnt_r <= frac_cnt_r - unit_exp;
        end
      end else if (cmd.step) begin
        if (hi_cnt_r != 4'd0) hi_cnt_r <= hi_cnt_r - 4'd1;
        if (lo_cnt_r != 4'd0) lo_cnt_r <= lo_cnt_r - 4'd1;
      end

      if (cmd.finish) out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;
    end
  end

  // scaling payload
  always_ff @(posedge clk) begin
    if (cmd.start) begin
      hi_r     <= whole_r;
      hi_ovf_r <= 1'b0;
      lo_r     <= {34'd0, frac_r};
      ok_r     <= end_ok && !err_r && !whole_ovf_r;
    end else if (cmd.step) begin
      if (hi_cnt_r != 4'd0) begin
        hi_r <= hi_x10[63:0];
        if (hi_x10[67:64] != 4'd0) hi_ovf_r <= 1'b1;
      end
      if (lo_cnt_r != 4'd0) begin
        // dividing only ever sees the raw fraction, below 2^30
        if (lo_mul_r) lo_r <= lo_x10;
        else lo_r <= {35'd0, lo_prod[63:dfp_pkg::DIV10_SHIFT]};
      end
    end
    if (cmd.finish) begin
      out_data_r.valid_res    <= res_ok;
      out_data_r.frequency_hz <= res_ok ? sum[63:0] : 64'd0;
    end
  end

  assign status.scale_done = (hi_cnt_r == 4'd0) && (lo_cnt_r == 4'd0);
  assign status.out_free   = !out_valid_r || out_ready;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

FILE: rtl/decimal_frequency_parser_top.sv
// Decimal frequency token parser.
// Input channel (in_valid/in_ready/in_data): one beat per character of an
// upper-case token such as "12.5 MHZ", then one beat with end_of_text set.
// Output channel (out_valid/out_ready/out_data): one beat per end beat,
// valid_res and the value in Hz (zero when not valid).
// Character beats are taken one per cycle with no result.
// After an end beat, in_ready drops while the value is scaled by repeated
// multiply/divide by ten, one decimal step at a time: the larger of the unit
// exponent (0/3/6/9) and its distance to the kept fraction digit count, then a
// check that the step counts have run out, then the final sum, which is
// registered on the output.
// The output register holds a finished result while out_ready is low; the
// next token's characters are still accepted meanwhile, and a second end beat
// waits only at the final sum stage until the register is free.
// Reset (rst_n low, synchronous) clears the parse state and drops out_valid.
module decimal_frequency_parser_top (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  dfp_pkg::in_t  in_data,
  output logic          out_valid,
  input  logic          out_ready,
  output dfp_pkg::out_t out_data
);

  dfp_pkg::cmd_t    cmd;
  dfp_pkg::status_t status;

  dfp_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_end   (in_data.end_of_text),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  dfp_datapath u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .character (in_data.character),
    .status    (status),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

FILE: rtl/dfp_checker.sv
module dfp_checker (
  input logic          clk,
  input logic          rst_n,
  input logic          in_valid,
  input logic          in_ready,
  input dfp_pkg::in_t  in_data,
  input logic          out_valid,
  input logic          out_ready,
  input dfp_pkg::out_t out_data
);

  // stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("output beat changed while stalled");

  a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.valid_res |-> out_data.frequency_hz == 64'd0)
    else $error("invalid result with nonzero frequency");

  a_end_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_data.end_of_text |=> !in_ready)
    else $error("input ready right after end beat");

  a_reset_clear: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("out_valid set after reset");

endmodule

bind decimal_frequency_parser_top dfp_checker u_dfp_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

FILE: test/tb_top.sv
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned STALL_LIMIT = 500;
  localparam int unsigned DRAIN_CYCLES = 20;
  localparam logic [63:0] U64_MAX = 64'hFFFF_FFFF_FFFF_FFFF;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  dfp_pkg::in_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  dfp_pkg::out_t out_data;

  decimal_frequency_parser_top dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data(out_data)
  );

  always #6 clk = ~clk;

  // Token parser shadow state
  dfp_pkg::phase_t p_phase = dfp_pkg::PH_FIRST;
  logic [63:0] p_whole = '0;
  bit p_whole_ovf = 1'b0;
  logic [31:0] p_frac = '0;
  int unsigned p_frac_cnt = 0;
  int unsigned p_sfx_cnt = 0;
  bit p_bad = 1'b0;

  dfp_pkg::out_t pending_freq[$];
  int unsigned errors = 0;
  int unsigned beats_sent = 0;
  int unsigned burst_left = 0;
  int unsigned stall_cycles = 0;
  logic [7:0] tok_chars[$];
  logic [7:0] rx_tick = '0;
  logic [1:0] rx_mode = '0;
  dfp_pkg::out_t want;

  // Directed tokens; an underscore stands for NUL
  localparam int DIR_N = 10;
  string dir_token[DIR_N] = '{"", "\3771", "_", "7", "5GHZ", "1.5KHZ", "3.", "2 \t",
                              "9KH", "4.2"};
  bit dir_typed[DIR_N] = '{1, 1, 1, 1, 1, 1, 1, 1, 1, 0};
  logic dir_ok[DIR_N] = '{0, 0, 0, 1, 1, 1, 1, 1, 0, 0};
  logic [63:0] dir_hz[DIR_N] = '{64'd0, 64'd0, 64'd0, 64'd7_000_000, 64'd5_000_000_000,
                                 64'd1500, 64'd3_000_000, 64'd2_000_000, 64'd0, 64'd0};

  function automatic string unit_text(dfp_pkg::phase_t ph);
    case (ph)
      dfp_pkg::PH_HZ: return "HZ";
      dfp_pkg::PH_KHZ: return "KHZ";
      dfp_pkg::PH_MHZ: return "MHZ";
      default: return "GHZ";
    endcase
  endfunction

  function automatic logic [63:0] unit_mult(dfp_pkg::phase_t ph);
    case (ph)
      dfp_pkg::PH_HZ: return 64'd1;
      dfp_pkg::PH_KHZ: return 64'd1000;
      dfp_pkg::PH_GHZ: return 64'd1_000_000_000;
      default: return 64'd1_000_000;
    endcase
  endfunction

  function automatic bit is_blank(logic [7:0] c);
    return c == 8'h20 || (c >= 8'h09 && c <= 8'h0D);
  endfunction

  function automatic bit is_num(logic [7:0] c);
    return c >= 8'h30 && c <= 8'h39;
  endfunction

  function automatic void begin_suffix(logic [7:0] c);
    p_sfx_cnt = 1;
    case (c)
      8'h48: p_phase = dfp_pkg::PH_HZ;
      8'h4B: p_phase = dfp_pkg::PH_KHZ;
      8'h4D: p_phase = dfp_pkg::PH_MHZ;
      8'h47: p_phase = dfp_pkg::PH_GHZ;
      default: p_bad = 1'b1;
    endcase
  endfunction

  function automatic void track_char(logic [7:0] c);
    logic [127:0] acc;
    string txt;
    if (p_bad) return;
    case (p_phase)
      dfp_pkg::PH_FIRST: begin
        if (is_num(c)) begin
          p_whole = 64'(c - 8'h30);
          p_phase = dfp_pkg::PH_WHOLE;
        end else begin
          p_bad = 1'b1;
        end
      end
      dfp_pkg::PH_WHOLE: begin
        if (is_num(c)) begin
          acc = 128'(p_whole) * 10 + 128'(c - 8'h30);
          if (acc > 128'(U64_MAX)) p_whole_ovf = 1'b1;
          else p_whole = acc[63:0];
        end else if (c == 8'h2E) begin
          p_phase = dfp_pkg::PH_FRAC;
        end else if (is_blank(c)) begin
          p_phase = dfp_pkg::PH_SPACE;
        end else begin
          begin_suffix(c);
        end
      end
      dfp_pkg::PH_FRAC: begin
        if (is_num(c)) begin
          if (p_frac_cnt < dfp_pkg::MAX_FRACTION_DIGITS) begin
            p_frac = p_frac * 10 + 32'(c - 8'h30);
            p_frac_cnt++;
          end
        end else if (is_blank(c)) begin
          p_phase = dfp_pkg::PH_SPACE;
        end else begin
          begin_suffix(c);
        end
      end
      dfp_pkg::PH_SPACE: begin
        if (!is_blank(c)) begin_suffix(c);
      end
      default: begin
        txt = unit_text(p_phase);
        if (p_sfx_cnt < txt.len() && c == txt[p_sfx_cnt]) p_sfx_cnt++;
        else p_bad = 1'b1;
      end
    endcase
  endfunction

  // End of token: value in Hz, then back to the idle parse state
  function automatic dfp_pkg::out_t close_token();
    dfp_pkg::out_t res;
    logic [63:0] mult;
    logic [127:0] scale, hi, lo;
    bit complete;
    string txt;
    res = '0;
    if (!p_bad && !p_whole_ovf && p_phase != dfp_pkg::PH_FIRST) begin
      mult = 64'd1_000_000;
      complete = 1'b1;
      if (p_phase >= dfp_pkg::PH_HZ) begin
        mult = unit_mult(p_phase);
        txt = unit_text(p_phase);
        complete = p_sfx_cnt == txt.len();
      end
      if (complete) begin
        scale = 1;
        repeat (p_frac_cnt) scale = scale * 10;
        hi = 128'(p_whole) * 128'(mult);
        lo = (128'(p_frac) * 128'(mult)) / scale;
        if (hi + lo <= 128'(U64_MAX)) begin
          res.valid_res = 1'b1;
          res.frequency_hz = 64'(hi + lo);
        end
      end
    end
    p_phase = dfp_pkg::PH_FIRST;
    p_whole = '0;
    p_whole_ovf = 1'b0;
    p_frac = '0;
    p_frac_cnt = 0;
    p_sfx_cnt = 0;
    p_bad = 1'b0;
    return res;
  endfunction

  task automatic send_beat(input logic [7:0] ch, input logic eot, input bit typed,
                           input logic typed_ok, input logic [63:0] typed_hz);
    dfp_pkg::out_t res;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      if ($urandom_range(0, 3) != 0) begin
        in_valid <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk);
      end
    end
    burst_left--;
    in_valid <= 1'b1;
    in_data <= '{character: ch, end_of_text: eot};
    do @(posedge clk); while (!in_ready);
    beats_sent++;
    if (eot) begin
      res = close_token();
      if (typed) begin
        res.valid_res = typed_ok;
        res.frequency_hz = typed_hz;
      end
      pending_freq.push_back(res);
    end else begin
      track_char(ch);
    end
  endtask

  // Mostly well-formed tokens with random content; some broken, some noise
  task automatic make_token();
    int unsigned mode, wmode, sfx, nf, pos;
    logic [63:0] w;
    string s, odd;
    odd = ".HKMGZ0 a";
    tok_chars.delete();
    mode = $urandom_range(0, 9);
    if (mode == 0) begin
      repeat ($urandom_range(0, 6)) tok_chars.push_back(8'($urandom));
      return;
    end
    sfx = $urandom_range(0, 4);
    wmode = $urandom_range(0, 5);
    case (wmode)
      0, 1, 2: w = 64'($urandom_range(0, 9999));
      3: w = {$urandom, $urandom};
      4: w = U64_MAX;
      default: w = sfx == 0 ? U64_MAX / 64'd1_000_000
                            : U64_MAX / unit_mult(dfp_pkg::phase_t'(3 + sfx));
    endcase
    s = $sformatf("%0d", w);
    if (wmode == 4) begin
      // around the 64-bit limit: last digit varied, sometimes one digit too many
      s[19] = 8'(8'h30 + $urandom_range(0, 9));
      if ($urandom_range(0, 3) == 0) s = {s, "7"};
    end
    if ($urandom_range(0, 7) == 0) s = {"0", s};
    if (wmode == 5 || $urandom_range(0, 2) == 0) begin
      s = {s, "."};
      nf = wmode == 5 ? 9 : $urandom_range(0, 12);
      repeat (nf) s = {s, string'(8'(8'h30 + $urandom_range(0, 9)))};
    end
    if ($urandom_range(0, 3) == 0) begin
      repeat ($urandom_range(1, 3)) begin
        if ($urandom_range(0, 1)) s = {s, " "};
        else s = {s, string'(8'($urandom_range(9, 13)))};
      end
    end
    if (sfx != 0) s = {s, unit_text(dfp_pkg::phase_t'(3 + sfx))};
    for (int i = 0; i < s.len(); i++) tok_chars.push_back(s[i]);
    if (mode <= 2) begin
      pos = $urandom_range(0, tok_chars.size() - 1);
      case ($urandom_range(0, 2))
        0: tok_chars[pos] = $urandom_range(0, 1) ? 8'($urandom)
                                                 : odd[$urandom_range(0, odd.len() - 1)];
        1: void'(tok_chars.pop_back());
        default: tok_chars.push_back(odd[$urandom_range(0, odd.len() - 1)]);
      endcase
    end
  endtask

  // Receiver: ready pattern switches whenever the low seven bits of rx_tick are zero
  always @(posedge clk) begin
    rx_tick <= rx_tick + 8'd1;
    if (rx_tick[6:0] == 7'd0) rx_mode <= 2'($urandom_range(0, 3));
    case (rx_mode)
      2'd0: out_ready <= 1'b1;
      2'd1: out_ready <= 1'($urandom_range(0, 1));
      2'd2: out_ready <= rx_tick[3:0] < 4'd3;
      default: out_ready <= $urandom_range(0, 7) != 0;
    endcase
    if (rst_n && out_valid && out_ready) begin
      if (pending_freq.size() == 0) begin
        $error("result beat with nothing pending");
        errors++;
      end else begin
        want = pending_freq.pop_front();
        if (out_data.valid_res !== want.valid_res) begin
          $error("valid_res: expected %0b, got %0b", want.valid_res, out_data.valid_res);
          errors++;
        end
        if (out_data.frequency_hz !== want.frequency_hz) begin
          $error("frequency_hz: expected %0d, got %0d", want.frequency_hz,
                 out_data.frequency_hz);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin
    string tk;
    logic [7:0] c;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    for (int r = 0; r < DIR_N; r++) begin
      tk = dir_token[r];
      for (int i = 0; i < tk.len(); i++) begin
        c = tk[i] == 8'h5F ? 8'h00 : tk[i];
        send_beat(c, 1'b0, 1'b0, 1'b0, '0);
      end
      send_beat(8'($urandom), 1'b1, dir_typed[r], dir_ok[r], dir_hz[r]);
    end
    while (beats_sent < 450) begin
      make_token();
      foreach (tok_chars[i]) send_beat(tok_chars[i], 1'b0, 1'b0, 1'b0, '0);
      send_beat(8'($urandom), 1'b1, 1'b0, 1'b0, '0);
    end
    in_valid <= 1'b0;
    while (pending_freq.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0) $display("Testbench completed without errors");
    else $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
